### src/assert_macros.svh
// Assertion macros shared by the RTL of the visibility grid binner.
// No dependencies; included by the files that carry concurrent assertions on i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of i_clk while reset is not asserted.
`define VGB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge of i_clk, reset included.
`define VGB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/vgb_pkg.sv
// Types and constants of the visibility grid binner.
// No dependencies; imported by every module and interface of the block.
package vgb_pkg;

    localparam int GRID_DIM    = 256;
    localparam int TILE_SIZE   = 16;
    localparam int OVERSAMPLE  = 8;
    localparam int COUNT_WIDTH = 16;

    localparam int COORD_W = 32;
    localparam int AMP_W   = 32;
    localparam int SCALE_W = 16;
    localparam int FRAC_W  = 32;
    localparam int PROD_W  = COORD_W + SCALE_W;
    localparam int GRID_W  = $clog2(GRID_DIM);
    localparam int TILE_W  = $clog2(TILE_SIZE);
    localparam int OVER_W  = $clog2(OVERSAMPLE);
    localparam int ADDR_W  = 2 * GRID_W;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd6554;

    typedef struct packed {
        logic              in_range;
        logic [GRID_W-1:0] pos;
        logic [OVER_W-1:0] over;
    } t_axis;

    typedef struct packed {
        logic signed [AMP_W-1:0] re;
        logic signed [AMP_W-1:0] im;
    } t_amp;

    typedef struct packed {
        logic                    in_bound;
        logic [GRID_W-1:0]       grid_u;
        logic [GRID_W-1:0]       grid_v;
        logic [OVER_W-1:0]       over_u;
        logic [OVER_W-1:0]       over_v;
        logic [TILE_W-1:0]       bin_x;
        logic [TILE_W-1:0]       bin_y;
        logic [GRID_W-TILE_W-1:0] tile_x;
        logic [GRID_W-TILE_W-1:0] tile_y;
        logic [COUNT_WIDTH-1:0]  hit_count;
        logic signed [AMP_W-1:0] out_real;
        logic signed [AMP_W-1:0] out_imag;
    } t_result;

endpackage

### src/vgb_in_if.sv
// Input channel of the visibility grid binner: one visibility per item.
// Depends on vgb_pkg.
interface vgb_in_if import vgb_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] u_coord;
    logic signed [COORD_W-1:0] v_coord;
    logic signed [AMP_W-1:0]   amp_real;
    logic signed [AMP_W-1:0]   amp_imag;

    modport source (output valid, u_coord, v_coord, amp_real, amp_imag, input ready);
    modport sink (input valid, u_coord, v_coord, amp_real, amp_imag, output ready);
endinterface

### src/vgb_out_if.sv
// Result channel of the visibility grid binner: one binned visibility per item.
// Depends on vgb_pkg.
interface vgb_out_if import vgb_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      in_bound;
    logic [GRID_W-1:0]         grid_u;
    logic [GRID_W-1:0]         grid_v;
    logic [OVER_W-1:0]         over_u;
    logic [OVER_W-1:0]         over_v;
    logic [TILE_W-1:0]         bin_x;
    logic [TILE_W-1:0]         bin_y;
    logic [GRID_W-TILE_W-1:0]  tile_x;
    logic [GRID_W-TILE_W-1:0]  tile_y;
    logic [COUNT_WIDTH-1:0]    hit_count;
    logic signed [AMP_W-1:0]   out_real;
    logic signed [AMP_W-1:0]   out_imag;

    modport source (output valid, in_bound, grid_u, grid_v, over_u, over_v, bin_x, bin_y,
                    tile_x, tile_y, hit_count, out_real, out_imag, input ready);
    modport sink (input valid, in_bound, grid_u, grid_v, over_u, over_v, bin_x, bin_y,
                  tile_x, tile_y, hit_count, out_real, out_imag, output ready);
endinterface

### src/vgb_cfg_if.sv
// Configuration write channel of the visibility grid binner (uv scale register).
// Depends on vgb_pkg.
interface vgb_cfg_if import vgb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SCALE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### src/visibility_grid_binner.sv
// Visibility grid binner: maps each visibility to a grid cell, bin and tile and
// counts hits per cell. Depends on vgb_pkg, the channel interfaces, vgb_coord_map,
// vgb_hit_ram and assert_macros.svh.
//
// Items enter on i_vis and leave on o_res, one result per item, in order, with
// valid/ready handshakes on both sides. The uv scale register is written through
// i_cfg, which is always ready; it should be written only while no item is in flight.
// An item accepted on i_vis passes through the scale product, axis and update-stage
// registers into the o_res output register; one item per cycle is sustained while
// the receiver keeps up. The pipeline runs scale multiply, cell decode, counter
// read and counter update; the single write and read ports of the counter store
// set that rate, and a write-back register forwards the count to a following item
// on the same cell. After reset the counter store's 65536 entries are cleared one
// entry per cycle; i_vis.ready stays low until then. When the receiver stalls, an
// output register and one skid register hold results; i_vis.ready drops only when
// both are full, and the whole pipeline then holds.
`include "assert_macros.svh"

module visibility_grid_binner import vgb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vgb_in_if.sink     i_vis,
    vgb_out_if.source  o_res,
    vgb_cfg_if.sink    i_cfg
);

    logic [SCALE_W-1:0]     r_scale;
    logic                   r_clearing;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic                   r_v1, r_v2, r_v3;
    t_amp                   r_amp1, r_amp2, r_amp3;
    t_axis                  ax_u, ax_v;
    t_axis                  r_s3_u, r_s3_v;
    logic                   r_s3_ok;
    logic [ADDR_W-1:0]      r_s3_addr;
    logic                   r_fw_valid;
    logic [ADDR_W-1:0]      r_fw_addr;
    logic [COUNT_WIDTH-1:0] r_fw_cnt;
    logic                   r_out_valid, r_skid_valid;
    t_result                r_out, r_skid;

    logic                   adv, acc, push, out_free, item_we;
    logic                   ok2;
    logic [ADDR_W-1:0]      addr2;
    logic [COUNT_WIDTH-1:0] rd_cnt, cur_cnt, n_cnt;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    t_result                res;

    assign adv         = !r_skid_valid;
    assign i_vis.ready = adv && !r_clearing;
    assign acc         = i_vis.valid && i_vis.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg.valid) begin
            r_scale <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    vgb_coord_map u_map_u (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_coord (i_vis.u_coord),
        .i_scale (r_scale),
        .o_axis  (ax_u)
    );

    vgb_coord_map u_map_v (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_coord (i_vis.v_coord),
        .i_scale (r_scale),
        .o_axis  (ax_v)
    );

    assign ok2   = ax_u.in_range && ax_v.in_range;
    assign addr2 = {ax_v.pos, ax_u.pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_amp1    <= '{re: i_vis.amp_real, im: i_vis.amp_imag};
            r_amp2    <= r_amp1;
            r_amp3    <= r_amp2;
            r_s3_u    <= ax_u;
            r_s3_v    <= ax_v;
            r_s3_ok   <= ok2;
            r_s3_addr <= addr2;
        end
    end

    // The write at the edge of this item's read is not in the read data;
    // take it from the write-back register.
    assign cur_cnt = (r_fw_valid && (r_fw_addr == r_s3_addr)) ? r_fw_cnt : rd_cnt;
    assign n_cnt   = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
    assign item_we = adv && r_v3 && r_s3_ok;

    assign mem_we    = r_clearing || item_we;
    assign mem_waddr = r_clearing ? r_clr_addr : r_s3_addr;
    assign mem_wdata = r_clearing ? '0 : n_cnt;

    vgb_hit_ram u_hit_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (adv),
        .i_raddr (addr2),
        .o_rdata (rd_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (item_we) begin
            r_fw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_we) begin
            r_fw_addr <= r_s3_addr;
            r_fw_cnt  <= n_cnt;
        end
    end

    always_comb begin
        res.in_bound  = r_s3_ok;
        res.grid_u    = r_s3_ok ? r_s3_u.pos : '0;
        res.grid_v    = r_s3_ok ? r_s3_v.pos : '0;
        res.over_u    = r_s3_u.over;
        res.over_v    = r_s3_v.over;
        res.bin_x     = r_s3_ok ? r_s3_u.pos[TILE_W-1:0] : '0;
        res.bin_y     = r_s3_ok ? r_s3_v.pos[TILE_W-1:0] : '0;
        res.tile_x    = r_s3_ok ? r_s3_u.pos[GRID_W-1:TILE_W] : '0;
        res.tile_y    = r_s3_ok ? r_s3_v.pos[GRID_W-1:TILE_W] : '0;
        res.hit_count = r_s3_ok ? n_cnt : '0;
        res.out_real  = r_amp3.re;
        res.out_imag  = r_amp3.im;
    end

    assign push     = adv && r_v3;
    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (push) begin
            r_skid <= res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.in_bound  = r_out.in_bound;
    assign o_res.grid_u    = r_out.grid_u;
    assign o_res.grid_v    = r_out.grid_v;
    assign o_res.over_u    = r_out.over_u;
    assign o_res.over_v    = r_out.over_v;
    assign o_res.bin_x     = r_out.bin_x;
    assign o_res.bin_y     = r_out.bin_y;
    assign o_res.tile_x    = r_out.tile_x;
    assign o_res.tile_y    = r_out.tile_y;
    assign o_res.hit_count = r_out.hit_count;
    assign o_res.out_real  = r_out.out_real;
    assign o_res.out_imag  = r_out.out_imag;

    `VGB_ASSERT(a_no_item_in_clear, r_clearing |-> !(r_v1 || r_v2 || r_v3), "item during clear")
    `VGB_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid, "skid full with output empty")
    `VGB_ASSERT(a_count_nonzero, item_we |=> (r_fw_valid && (r_fw_cnt != '0)), "zero hit count")

endmodule

### src/vgb_coord_map.sv
// One axis of the coordinate mapping: registered scale multiply, then a
// registered floor, center offset, bound check and oversample index. Depends on vgb_pkg.
module vgb_coord_map import vgb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [COORD_W-1:0] i_coord,
    input  logic [SCALE_W-1:0]        i_scale,
    output t_axis                     o_axis
);

    logic signed [PROD_W:0]   full_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic [PROD_W-FRAC_W-GRID_W:0] whole_hi;
    t_axis n_axis;
    t_axis r_axis;

    assign full_prod = i_coord * $signed({1'b0, i_scale});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= full_prod[PROD_W-1:0];
            r_axis <= n_axis;
        end
    end

    // The floor of the product is its upper part; adding half the grid flips the cell's top bit.
    assign whole_hi = r_prod[PROD_W-1:FRAC_W+GRID_W-1];

    always_comb begin
        n_axis.in_range = (&whole_hi) || (~|whole_hi);
        n_axis.pos      = {~r_prod[FRAC_W+GRID_W-1], r_prod[FRAC_W+GRID_W-2:FRAC_W]};
        n_axis.over     = r_prod[FRAC_W-1:FRAC_W-OVER_W];
    end

    assign o_axis = r_axis;

endmodule

### src/vgb_hit_ram.sv
// Hit counter store: one write port and one read port with registered read data.
// Depends on vgb_pkg.
module vgb_hit_ram import vgb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  logic [COUNT_WIDTH-1:0] i_wdata,
    input  logic                   i_re,
    input  logic [ADDR_W-1:0]      i_raddr,
    output logic [COUNT_WIDTH-1:0] o_rdata
);

    logic [COUNT_WIDTH-1:0] r_mem [2**ADDR_W];
    logic [COUNT_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### test/vgb_binning_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the visibility grid binner: watches the visibility, result and scale channels,
// predicts every binned result with its own copy of the hit counters and compares field by field.
// Depends on vgb_pkg and the channel interfaces vgb_in_if, vgb_out_if and vgb_cfg_if.
module vgb_binning_checker import vgb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    vgb_in_if    i_vis,
    vgb_out_if   i_res,
    vgb_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_in_bound
);

    logic [SCALE_W-1:0]     uv_scale = SCALE_RESET;
    bit [COUNT_WIDTH-1:0]   cell_hits [GRID_DIM*GRID_DIM];
    t_result                expected_bins [$];

    function automatic void map_axis(input logic signed [COORD_W-1:0] coord,
                                     output int pos, output logic [OVER_W-1:0] over);
        longint prod;
        prod = longint'(coord) * longint'(uv_scale);
        pos  = int'(prod >>> FRAC_W) + GRID_DIM / 2;
        over = prod[FRAC_W-1 -: OVER_W];
    endfunction

    function automatic t_result bin_visibility(input logic signed [COORD_W-1:0] u, v,
                                               input logic signed [AMP_W-1:0] re, im);
        t_result            r;
        int                 cu, cv, idx;
        logic [OVER_W-1:0]  ou, ov;
        map_axis(u, cu, ou);
        map_axis(v, cv, ov);
        r = '0;
        r.over_u   = ou;
        r.over_v   = ov;
        r.out_real = re;
        r.out_imag = im;
        if (cu >= 0 && cu < GRID_DIM && cv >= 0 && cv < GRID_DIM) begin
            idx = cv * GRID_DIM + cu;
            if (cell_hits[idx] != '1) begin
                cell_hits[idx] = cell_hits[idx] + 1'b1;
            end
            r.in_bound  = 1'b1;
            r.grid_u    = GRID_W'(cu);
            r.grid_v    = GRID_W'(cv);
            r.bin_x     = TILE_W'(cu % TILE_SIZE);
            r.bin_y     = TILE_W'(cv % TILE_SIZE);
            r.tile_x    = (GRID_W-TILE_W)'(cu / TILE_SIZE);
            r.tile_y    = (GRID_W-TILE_W)'(cv / TILE_SIZE);
            r.hit_count = cell_hits[idx];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [AMP_W-1:0] want, got);
        if (got !== want) begin
            $error("result field %s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result item;
        if (!i_rst_n) begin
            uv_scale = SCALE_RESET;
            expected_bins.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_bins.size() == 0) begin
                    $error("result item arrived with no visibility outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_bins.pop_front();
                    o_checked++;
                    if (want.in_bound) begin
                        o_in_bound++;
                    end
                    check_field("in_bound", want.in_bound, i_res.in_bound);
                    check_field("grid_u", want.grid_u, i_res.grid_u);
                    check_field("grid_v", want.grid_v, i_res.grid_v);
                    check_field("over_u", want.over_u, i_res.over_u);
                    check_field("over_v", want.over_v, i_res.over_v);
                    check_field("bin_x", want.bin_x, i_res.bin_x);
                    check_field("bin_y", want.bin_y, i_res.bin_y);
                    check_field("tile_x", want.tile_x, i_res.tile_x);
                    check_field("tile_y", want.tile_y, i_res.tile_y);
                    check_field("hit_count", want.hit_count, i_res.hit_count);
                    check_field("out_real", want.out_real, i_res.out_real);
                    check_field("out_imag", want.out_imag, i_res.out_imag);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                uv_scale = i_cfg.data;
            end
            if (i_vis.valid && i_vis.ready) begin
                item = bin_visibility(i_vis.u_coord, i_vis.v_coord,
                                      i_vis.amp_real, i_vis.amp_imag);
                expected_bins = {expected_bins, item};
            end
        end
        o_pending = expected_bins.size();
    end

endmodule

### test/tb_visibility_grid_binner.sv
`timescale 1ns / 1ps
// Testbench top for the visibility grid binner: drives visibilities, scale writes and result
// back-pressure, and gives the verdict. Depends on vgb_pkg, the channel interfaces,
// visibility_grid_binner and vgb_binning_checker.
module tb_visibility_grid_binner;
    import vgb_pkg::*;

    localparam int     CYCLE_LIMIT      = 1_000_000;
    localparam int     PHASE_ITEMS      = 260;
    localparam int     TAIL_ITEMS       = 40;
    localparam int     ZERO_SCALE_ITEMS = 100;
    localparam int     GAP_CAP          = 20;
    localparam longint COORD_MAX        = 64'sd2147483647;
    localparam longint COORD_MIN        = -64'sd2147483648;

    logic                      i_clk;
    logic                      i_rst_n;
    int                        send_idle_pct;
    int                        recv_stall_pct;
    int                        cycle_count;
    int                        sent_items;
    logic [SCALE_W-1:0]        cur_scale;
    logic signed [COORD_W-1:0] hot_u [4];
    logic signed [COORD_W-1:0] hot_v [4];
    int                        fail_count;
    int                        pending;
    int                        checked;
    int                        in_bound_seen;

    vgb_in_if  vis_if ();
    vgb_out_if res_if ();
    vgb_cfg_if cfg_if ();

    visibility_grid_binner u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vis   (vis_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    vgb_binning_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vis        (vis_if),
        .i_res        (res_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_in_bound   (in_bound_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        res_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int idle_gap(input int pct);
        int n = 0;
        while (n < GAP_CAP && $urandom_range(99) < pct) n++;
        return n;
    endfunction

    // Picks a coordinate whose scaled value lands near the given cell offset and fraction.
    function automatic logic signed [COORD_W-1:0] aim_coord(input int offset,
                                                            input logic [31:0] frac);
        longint target, c;
        if (cur_scale == '0) begin
            return $urandom;
        end
        target = (longint'(offset) <<< 32) + longint'(frac);
        c = target / longint'(cur_scale);
        if (c > COORD_MAX) c = COORD_MAX;
        if (c < COORD_MIN) c = COORD_MIN;
        return c[COORD_W-1:0];
    endfunction

    task automatic send_vis(input logic signed [COORD_W-1:0] u, v,
                            input logic signed [AMP_W-1:0] re, im);
        int gap;
        gap = idle_gap(send_idle_pct);
        if (gap > 0) begin
            vis_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        vis_if.valid    = 1'b1;
        vis_if.u_coord  = u;
        vis_if.v_coord  = v;
        vis_if.amp_real = re;
        vis_if.amp_imag = im;
        @(posedge i_clk);
        while (!vis_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_items++;
    endtask

    task automatic send_random_vis();
        logic signed [COORD_W-1:0] u, v;
        int                        pick, slot;
        pick = $urandom_range(99);
        slot = $urandom_range(3);
        if (pick < 25) begin
            u = hot_u[slot];
            v = hot_v[slot];
        end else if (pick < 85) begin
            u = aim_coord(int'($urandom_range(259)) - 130, $urandom);
            v = aim_coord(int'($urandom_range(259)) - 130, $urandom);
            if (pick < 45) begin
                hot_u[slot] = u;
                hot_v[slot] = v;
            end
        end else begin
            u = $urandom;
            v = $urandom;
        end
        send_vis(u, v, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        vis_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] s);
        wait_drained();
        cfg_if.valid = 1'b1;
        cfg_if.data  = s;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
        cur_scale    = s;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        vis_if.valid    = 1'b0;
        vis_if.u_coord  = '0;
        vis_if.v_coord  = '0;
        vis_if.amp_real = '0;
        vis_if.amp_imag = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        cur_scale       = SCALE_RESET;
        for (int i = 0; i < 4; i++) begin
            hot_u[i] = '0;
            hot_v[i] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items at the reset scale: center cell, repeats, far-off and edge cells,
        // every oversample index and the amplitude extremes.
        send_vis('0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_vis('0, '0, '0, -32'sd1);
        send_vis(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_vis(32'sh8000_0000, 32'sh8000_0000, -32'sd1, '0);
        send_vis(32'sh7FFF_FFFF, '0, $urandom, $urandom);
        send_vis('0, 32'sh8000_0000, $urandom, $urandom);
        foreach (hot_u[i]) begin
            int edge_off;
            edge_off = (i == 0) ? -129 : (i == 1) ? -128 : (i == 2) ? 127 : 128;
            send_vis(aim_coord(edge_off, 32'h8000_0000), aim_coord(0, 32'h8000_0000),
                     $urandom, $urandom);
            send_vis(aim_coord(0, 32'h8000_0000), aim_coord(edge_off, 32'h8000_0000),
                     $urandom, $urandom);
        end
        for (int k = 0; k < OVERSAMPLE; k++) begin
            send_vis(aim_coord(-3, (k << 29) | (1 << 28)),
                     aim_coord(2, ((OVERSAMPLE - 1 - k) << 29) | (1 << 28)),
                     $urandom, $urandom);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_scale(16'hFFFF);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    write_scale(SCALE_W'($urandom_range(2, 65534)));
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                end
                2: begin
                    write_scale(SCALE_W'($urandom_range(2, 65534)));
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                end
                default: begin
                    write_scale(SCALE_W'($urandom_range(2, 65534)));
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            repeat (PHASE_ITEMS) send_random_vis();
        end

        // With a zero scale every visibility lands on the center cell, so one counter
        // is updated back to back through the forwarding path.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_scale('0);
        repeat (ZERO_SCALE_ITEMS) send_vis($urandom, $urandom, $urandom, $urandom);

        write_scale(16'd1);
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        repeat (TAIL_ITEMS) send_random_vis();

        wait_drained();
        $display("Summary: %0d visibilities, seven scale settings, four handshake mixes;",
                 sent_items);
        $display("Summary: one cell hit back to back; %0d results compared, %0d in bound.",
                 checked, in_bound_seen);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
